FILE: hdl/rspe_pkg.sv
package rspe_pkg;

   localparam int SYM_BITS     = 8;
   localparam int MAX_PARITY   = 16;
   localparam int IDX_BITS     = 4;
   localparam int CNT_BITS     = 5;
   localparam int POLY_BITS    = 9;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DW       = 9;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PRIM_POLY = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_N_PARITY  = 1'b1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   localparam logic [POLY_BITS-1:0] PRIM_POLY_RESET = 9'd285;
   localparam logic [CNT_BITS-1:0]  N_PARITY_RESET  = 5'd16;
   localparam logic [CNT_BITS-1:0]  NPAR_MIN        = 5'd2;
   localparam logic [CNT_BITS-1:0]  NPAR_MAX        = CNT_BITS'(MAX_PARITY);

   typedef logic [SYM_BITS-1:0] sym_type;
   typedef sym_type [MAX_PARITY-1:0] parity_type;

   // Handoff from the LFSR to the output burst when a block finishes.
   typedef struct packed {
      logic                valid;
      logic [CNT_BITS-1:0] count;
   } block_done_type;

endpackage

FILE: hdl/rspe_gf_mul.sv
module rspe_gf_mul
   import rspe_pkg::*;
(
   input  sym_type a,
   input  sym_type b,
   input  sym_type red,
   output sym_type prod
);

   sym_type acc;
   sym_type sh;

   // Shift-and-add product, reducing by the field polynomial at each shift.
   always_comb begin
      acc = '0;
      sh  = a;
      for (int i = 0; i < SYM_BITS; i++) begin
         if (b[i]) begin
            acc = acc ^ sh;
         end
         if (sh[SYM_BITS-1]) begin
            sh = {sh[SYM_BITS-2:0], 1'b0} ^ red;
         end else begin
            sh = {sh[SYM_BITS-2:0], 1'b0};
         end
      end
      prod = acc;
   end

endmodule

FILE: hdl/rspe_lfsr.sv
module rspe_lfsr
   import rspe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 command,
   input  logic [IDX_BITS-1:0]  coef_index,
   input  sym_type              symbol,
   input  logic                 is_last,
   input  logic [POLY_BITS-1:0] prim_poly,
   input  logic [CNT_BITS-1:0]  n_parity,
   output parity_type           block_parity,
   output block_done_type       done
);

   parity_type          parity_ff;
   parity_type          parity_in;
   parity_type          coef_ff;
   parity_type          prod;
   logic [CNT_BITS-1:0] n_act;
   logic [CNT_BITS-1:0] n_top;
   sym_type             fb;
   logic                data_fire;

   always_comb begin
      if (n_parity < NPAR_MIN) begin
         n_act = NPAR_MIN;
      end else if (n_parity > NPAR_MAX) begin
         n_act = NPAR_MAX;
      end else begin
         n_act = n_parity;
      end
   end

   assign n_top     = n_act - 1'b1;
   assign fb        = symbol ^ parity_ff[n_top[IDX_BITS-1:0]];
   assign data_fire = accept && (command == CMD_DATA);

   for (genvar j = 0; j < MAX_PARITY; j++) begin : g_tap
      rspe_gf_mul u_mul (
         .a    (coef_ff[j]),
         .b    (fb),
         .red  (prim_poly[SYM_BITS-1:0]),
         .prod (prod[j])
      );
   end

   // Taps at or above the active count hold their value.
   always_comb begin
      parity_in[0] = prod[0];
      for (int j = 1; j < MAX_PARITY; j++) begin
         if (CNT_BITS'(j) < n_act) begin
            parity_in[j] = parity_ff[j-1] ^ prod[j];
         end else begin
            parity_in[j] = parity_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= '0;
      end else if (data_fire) begin
         parity_ff <= is_last ? '0 : parity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (command == CMD_LOAD)) begin
         coef_ff[coef_index] <= symbol;
      end
   end

   assign block_parity = parity_in;
   assign done.valid   = data_fire && is_last;
   assign done.count   = n_act;

endmodule

FILE: hdl/rspe_burst.sv
module rspe_burst
   import rspe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  block_done_type      done,
   input  parity_type          block_parity,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic                rsp_tlast,
   output sym_type             rsp_symbol,
   output logic [IDX_BITS-1:0] rsp_index,
   output logic                free
);

   logic                busy_ff;
   logic [IDX_BITS-1:0] cnt_ff;
   logic [CNT_BITS-1:0] len_ff;
   parity_type          buf_ff;
   logic                take;
   logic                at_end;
   logic                final_beat;

   assign take       = busy_ff && rsp_tready;
   assign at_end     = (CNT_BITS'(cnt_ff) + 1'b1) == len_ff;
   assign final_beat = take && at_end;
   assign free       = !busy_ff || final_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         len_ff  <= NPAR_MIN;
      end else if (done.valid) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         len_ff  <= done.count;
      end else if (final_beat) begin
         busy_ff <= 1'b0;
      end else if (take) begin
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         buf_ff <= block_parity;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = busy_ff && at_end;
   assign rsp_symbol = buf_ff[cnt_ff];
   assign rsp_index  = cnt_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      done.valid && busy_ff |-> final_beat)
      else $error("burst reloaded while words remain");

   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (CNT_BITS'(cnt_ff) < len_ff))
      else $error("burst index beyond block length");

   a_cnt_steps: assert property (@(posedge clock) disable iff (reset)
      take && !at_end && !done.valid |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("burst index did not advance");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (len_ff >= NPAR_MIN) && (len_ff <= NPAR_MAX))
      else $error("burst length out of range");

endmodule

FILE: hdl/reed_solomon_parity_encoder.sv
// Systematic Reed-Solomon parity generator over GF(2^8), built as an LFSR whose
// taps all update in the same cycle. Each input word is either a generator
// coefficient load (tuser low: coefficient index and value) or a message symbol
// (tuser high), sent highest message index first; tlast on a message symbol ends
// the block. Words may arrive back to back. The cycle after the last symbol of a
// block, its parity symbols start leaving on the result channel, index 0 first,
// one word per cycle while the receiver is ready, with tlast on the final one;
// the LFSR is cleared for the next block at the same time, so the next block's
// symbols may stream in while the burst drains. The burst holds one block: a
// block-ending symbol is only taken once the previous burst is handing over its
// final word, so a ready receiver sustains one word per cycle if no block has
// fewer message symbols than parity symbols. The field polynomial (its low eight
// bits, the x^8 term being implied) and the parity count (clamped to 2..16) are
// written through the csr port; the user must write them only while the block is
// idle, which the block does not enforce; coefficients must be loaded before use.
module reed_solomon_parity_encoder
   import rspe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,  // coef_index[3:0], symbol[11:4], zero
   input  logic                    req_tuser,  // command
   input  logic                    req_tlast,  // is_last

   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,  // parity_symbol[7:0], parity_index[11:8], zero
   output logic                    rsp_tlast,  // last_parity

   input  logic                    csr_wen,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_DW-1:0]       csr_wdata
);

   logic [POLY_BITS-1:0] prim_poly_ff;
   logic [CNT_BITS-1:0]  n_parity_ff;
   logic                 accept;
   logic                 burst_free;
   parity_type           block_parity;
   block_done_type       done;
   sym_type              rsp_symbol;
   logic [IDX_BITS-1:0]  rsp_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_poly_ff <= PRIM_POLY_RESET;
         n_parity_ff  <= N_PARITY_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PRIM_POLY: prim_poly_ff <= csr_wdata[POLY_BITS-1:0];
            CSR_N_PARITY:  n_parity_ff  <= csr_wdata[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Only a block-ending message symbol needs the burst register to be free.
   assign req_tready = burst_free || !((req_tuser == CMD_DATA) && req_tlast);
   assign accept     = req_tvalid && req_tready;

   rspe_lfsr u_lfsr (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .command      (req_tuser),
      .coef_index   (req_tdata[IDX_BITS-1:0]),
      .symbol       (req_tdata[IDX_BITS+SYM_BITS-1:IDX_BITS]),
      .is_last      (req_tlast),
      .prim_poly    (prim_poly_ff),
      .n_parity     (n_parity_ff),
      .block_parity (block_parity),
      .done         (done)
   );

   rspe_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .done         (done),
      .block_parity (block_parity),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tlast    (rsp_tlast),
      .rsp_symbol   (rsp_symbol),
      .rsp_index    (rsp_index),
      .free         (burst_free)
   );

   assign rsp_tdata = {4'b0000, rsp_index, rsp_symbol};

endmodule

FILE: sim/reed_solomon_parity_encoder_test.sv
`timescale 1ns / 100ps

module reed_solomon_parity_encoder_test;
   import rspe_pkg::*;

   // One parity word as the block should deliver it on the result channel.
   typedef struct {
      sym_type             symbol;
      logic [IDX_BITS-1:0] index;
      logic                last;
   } parity_word_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [15:0]             req_tdata  = '0;  // coef_index[3:0], symbol[11:4], zero
   logic                    req_tuser  = CMD_LOAD;  // command
   logic                    req_tlast  = 1'b0;  // is_last

   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [15:0]             rsp_tdata;  // parity_symbol[7:0], parity_index[11:8], zero
   logic                    rsp_tlast;  // last_parity

   logic                    csr_wen    = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index  = CSR_PRIM_POLY;
   logic [CSR_DW-1:0]       csr_wdata  = '0;

   // Our own copy of the encoder: field polynomial, parity count, LFSR taps and the
   // generator coefficients, plus the parity words still owed by the block.
   logic [POLY_BITS-1:0]    field_poly;
   logic [CNT_BITS-1:0]     parity_count;
   sym_type                 lfsr_taps [MAX_PARITY];
   sym_type                 generator [MAX_PARITY];
   parity_word_type         parity_queue [$];

   // Percent chance per cycle that the sender or the receiver sits idle.
   int                      send_idle_pct = 0;
   int                      recv_idle_pct = 0;
   // A long receiver hold-off is requested here and counted down by the receiver.
   int                      hold_request  = 0;
   int                      hold_left     = 0;
   int                      words_sent    = 0;
   int                      mismatches    = 0;

   reed_solomon_parity_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // The run must be over long before this; a hang ends here as a failure.
   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

   // GF(2^8) product, reduced by the low eight bits of the field polynomial. The
   // x^8 term is always implied, so any register value gives a defined product.
   function automatic sym_type gf_product(sym_type a, sym_type b);
      sym_type acc;
      sym_type red;
      acc = '0;
      red = field_poly[SYM_BITS-1:0];
      for (int i = 0; i < SYM_BITS; i++) begin
         if (b[i]) begin
            acc ^= a;
         end
         a = a[SYM_BITS-1] ? ((a << 1) ^ red) : (a << 1);
      end
      return acc;
   endfunction

   // The parity count register is clamped to 2..16 by the block.
   function automatic int taps_in_use();
      if (parity_count < NPAR_MIN) begin
         return NPAR_MIN;
      end
      if (parity_count > NPAR_MAX) begin
         return NPAR_MAX;
      end
      return parity_count;
   endfunction

   // Offer one word, wait for the handshake, then update our copy of the generator or the LFSR.
   // The valid stays high after acceptance; it is only lowered for a gap or a pause,
   // so it never gets two assignments in one time step.
   task automatic send_word(logic cmd, logic [IDX_BITS-1:0] idx, sym_type sym, logic last);
      int      gap;
      int      n;
      sym_type feedback;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= last;
      req_tdata  <= {4'b0000, sym, idx};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (cmd == CMD_LOAD) begin
         // A load never produces a result, even with tlast set.
         generator[idx] = sym;
      end else begin
         n        = taps_in_use();
         feedback = sym ^ lfsr_taps[n-1];
         for (int j = n - 1; j > 0; j--) begin
            lfsr_taps[j] = lfsr_taps[j-1] ^ gf_product(generator[j], feedback);
         end
         lfsr_taps[0] = gf_product(generator[0], feedback);
         if (last) begin
            for (int j = 0; j < n; j++) begin
               parity_queue.push_back('{lfsr_taps[j], IDX_BITS'(j), j == n - 1});
            end
            // All sixteen taps clear at the end of a block, not only the active ones.
            lfsr_taps = '{default: '0};
         end
      end
   endtask

   // Sender pauses until every owed parity word has arrived, then lets the block settle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (parity_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DW-1:0] value);
      settle();
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_PRIM_POLY) begin
         field_poly = value[POLY_BITS-1:0];
      end else begin
         parity_count = value[CNT_BITS-1:0];
      end
      @(posedge clock);
   endtask

   // Receiver: random stalls, or a long solid hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic note_mismatch(string what, parity_word_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s): expected symbol %h index %0d last %b, got %h %0d %b",
                  what, want.symbol, want.index, want.last,
                  rsp_tdata[7:0], rsp_tdata[11:8], rsp_tlast);
      end
   endtask

   // Every accepted parity word is compared against the oldest expectation.
   always @(posedge clock) begin
      parity_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (parity_queue.size() == 0) begin
            want = '{'0, '0, 1'b0};
            note_mismatch("unexpected word", want);
         end else begin
            want = parity_queue.pop_front();
            if (rsp_tdata[7:0] !== want.symbol || rsp_tdata[11:8] !== want.index ||
                rsp_tlast !== want.last) begin
               note_mismatch("wrong field", want);
            end
         end
      end
   end

   // Loads every generator coefficient, including the zero and all-ones values.
   // One load carries tlast, which the block must ignore.
   task automatic test_coefficient_load();
      sym_type value;
      for (int i = 0; i < MAX_PARITY; i++) begin
         value = (i == 3) ? 8'h00 : (i == 7) ? 8'hFF : sym_type'($urandom_range(1, 254));
         send_word(CMD_LOAD, IDX_BITS'(i), value, i == 5);
      end
   endtask

   // A block built from the extreme symbol values at the reset settings.
   task automatic test_extreme_symbols();
      send_word(CMD_DATA, 4'hF, 8'hFF, 1'b0);
      send_word(CMD_DATA, 4'h0, 8'h00, 1'b0);
      send_word(CMD_DATA, 4'h0, 8'h80, 1'b1);
   endtask

   // Parity counts below the minimum and above the maximum are clamped; the
   // minimum itself is checked too. Each uses a one-symbol block.
   task automatic test_parity_count();
      write_register(CSR_N_PARITY, 9'd0);
      send_word(CMD_DATA, 4'h0, sym_type'($urandom), 1'b1);
      write_register(CSR_N_PARITY, 9'd31);
      send_word(CMD_DATA, 4'hA, sym_type'($urandom), 1'b1);
      write_register(CSR_N_PARITY, 9'd2);
      send_word(CMD_DATA, 4'h5, sym_type'($urandom), 1'b1);
   endtask

   // A polynomial with the x^8 bit clear and one that is not primitive still
   // have to give the same products as the implied-x^8 reduction.
   task automatic test_field_polynomial();
      write_register(CSR_N_PARITY, 9'd16);
      write_register(CSR_PRIM_POLY, 9'd0);
      send_word(CMD_DATA, 4'h0, 8'hFF, 1'b1);
      write_register(CSR_PRIM_POLY, 9'h1FF);
      send_word(CMD_DATA, 4'h0, 8'hC3, 1'b1);
   endtask

   // The parity count changes in the middle of a block while the block is idle;
   // the remaining symbols use the new count, and all taps clear at the end.
   task automatic test_count_change_in_block();
      write_register(CSR_PRIM_POLY, 9'd285);
      send_word(CMD_DATA, 4'h0, sym_type'($urandom), 1'b0);
      write_register(CSR_N_PARITY, 9'd5);
      send_word(CMD_DATA, 4'h0, sym_type'($urandom), 1'b1);
   endtask

   // Picks a new field polynomial or parity count, favoring the extremes.
   task automatic pick_settings();
      int pick;
      pick = $urandom_range(11);
      case (pick)
         0: write_register(CSR_PRIM_POLY, 9'd256);
         1: write_register(CSR_PRIM_POLY, 9'd511);
         2: write_register(CSR_PRIM_POLY, 9'd285);
         3: write_register(CSR_PRIM_POLY, 9'd301);
         4: write_register(CSR_PRIM_POLY, CSR_DW'($urandom_range(0, 511)));
         5: write_register(CSR_N_PARITY, 9'd2);
         6: write_register(CSR_N_PARITY, 9'd16);
         default: write_register(CSR_N_PARITY, CSR_DW'($urandom_range(0, 31)));
      endcase
   endtask

   // Mostly whole blocks of random symbols, mixed with coefficient reloads (some
   // carrying tlast), one-symbol blocks and changes of the settings.
   task automatic test_random_traffic(int words_wanted);
      int stop_at;
      int choice;
      int len;
      stop_at = words_sent + words_wanted;
      while (words_sent < stop_at) begin
         choice = $urandom_range(99);
         if (choice < 5) begin
            pick_settings();
         end else if (choice < 14) begin
            send_word(CMD_LOAD, IDX_BITS'($urandom), sym_type'($urandom), 1'($urandom));
         end else if (choice < 20) begin
            send_word(CMD_DATA, IDX_BITS'($urandom), sym_type'($urandom), 1'b1);
         end else begin
            len = $urandom_range(2, 24);
            for (int k = 0; k < len; k++) begin
               send_word(CMD_DATA, IDX_BITS'($urandom), sym_type'($urandom), k == len - 1);
            end
         end
      end
   endtask

   // The receiver holds off for a long stretch while short blocks arrive back to
   // back: the burst buffer fills and the block has to stall its input.
   task automatic test_output_backpressure();
      write_register(CSR_N_PARITY, 9'd16);
      send_idle_pct = 0;
      hold_request  = 400;
      for (int b = 0; b < 4; b++) begin
         for (int k = 0; k < 3; k++) begin
            send_word(CMD_DATA, 4'h0, sym_type'($urandom), k == 2);
         end
      end
      settle();
   endtask

   initial begin
      field_poly   = PRIM_POLY_RESET;
      parity_count = N_PARITY_RESET;
      lfsr_taps    = '{default: '0};
      generator    = '{default: '0};

      send_idle_pct = 21;
      recv_idle_pct = 80;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_coefficient_load();
      test_extreme_symbols();
      test_parity_count();
      test_field_polynomial();
      test_count_change_in_block();

      write_register(CSR_PRIM_POLY, 9'd285);
      write_register(CSR_N_PARITY, 9'd16);
      test_random_traffic(150);

      send_idle_pct = 80;
      recv_idle_pct = 21;
      test_random_traffic(150);

      test_output_backpressure();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(150);

      // Let everything drain, then watch a little longer for stray words.
      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && parity_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/rspe_pkg.sv
hdl/rspe_gf_mul.sv
hdl/rspe_lfsr.sv
hdl/rspe_burst.sv
hdl/reed_solomon_parity_encoder.sv
sim/reed_solomon_parity_encoder_test.sv
